/* rtl/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and helper functions of the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int VALUE_BITS = 32;
   localparam int EXP_BITS   = $clog2(VALUE_BITS);
   localparam int RADIX_BITS = 6;
   localparam int DIGIT_BITS = 6;
   localparam int CHAR_BITS  = 7;
   localparam int PROD_BITS  = VALUE_BITS + RADIX_BITS;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO   = CHAR_BITS'(48);
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = CHAR_BITS'(97);
   localparam logic [DIGIT_BITS-1:0] DECIMAL_DIGITS = DIGIT_BITS'(10);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIGIT,
      ST_EMIT
   } state_type;

   function automatic logic [RADIX_BITS-1:0] saturate_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] result;
      result = r;
      if (r < RADIX_MIN) begin
         result = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         result = RADIX_MAX;
      end
      return result;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] result;
      if (d < DECIMAL_DIGITS) begin
         result = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         result = CHAR_LOWER_A + CHAR_BITS'(d - DECIMAL_DIGITS);
      end
      return result;
   endfunction

endpackage

/* rtl/radix_digit_converter_top.sv */
// ----------------------------------------------------------------------------
// radix_digit_converter_top
// Converts an unsigned value into lower-case ASCII digits of a set radix.
// ----------------------------------------------------------------------------
// Each request transfer carries one value; the block answers with one response
// transfer per digit, most significant first, with rsp_last on the final digit.
// The radix register (2 to 36, reset 10) saturates out-of-range writes. A
// multiplier and a compare/subtract path do all the work: the block first
// multiplies up the place power once per digit, then finds each digit by
// subtracting the place power as often as it fits, then presents the digit
// and holds it until rsp_ready takes it. The block takes no new request
// until the last digit has been transferred.
module radix_digit_converter_top
   import rdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RADIX_BITS-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_BITS-1:0]  rsp_digit_char,
   output logic                  rsp_last
);

   state_type             state_ff, state_in;
   logic [RADIX_BITS-1:0] radix_ff;
   logic [VALUE_BITS-1:0] remaining_ff, remaining_in;
   logic [VALUE_BITS-1:0] power_ff, power_in;
   logic [EXP_BITS-1:0]   exp_ff, exp_in;
   logic [DIGIT_BITS-1:0] digit_ff, digit_in;
   logic [VALUE_BITS-1:0] pow_table_ff [VALUE_BITS];
   logic                  pow_we;
   logic [EXP_BITS-1:0]   pow_waddr;
   logic [VALUE_BITS-1:0] pow_wdata;
   logic [PROD_BITS-1:0]  product;

   assign csr_ready      = 1'b1;
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_EMIT);
   assign rsp_digit_char = digit_to_ascii(digit_ff);
   assign rsp_last       = (exp_ff == '0);
   assign product        = PROD_BITS'(power_ff) * PROD_BITS'(radix_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            radix_ff <= saturate_radix(csr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      remaining_ff <= remaining_in;
      power_ff     <= power_in;
      exp_ff       <= exp_in;
      digit_ff     <= digit_in;
      if (pow_we) begin
         pow_table_ff[pow_waddr] <= pow_wdata;
      end
   end

   always_comb begin
      state_in     = state_ff;
      remaining_in = remaining_ff;
      power_in     = power_ff;
      exp_in       = exp_ff;
      digit_in     = digit_ff;
      pow_we       = 1'b0;
      pow_waddr    = exp_ff + EXP_BITS'(1);
      pow_wdata    = product[VALUE_BITS-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               remaining_in = req_value;
               power_in     = VALUE_BITS'(1);
               exp_in       = '0;
               digit_in     = '0;
               pow_we       = 1'b1;
               pow_waddr    = '0;
               pow_wdata    = VALUE_BITS'(1);
               state_in     = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (product <= PROD_BITS'(remaining_ff)) begin
               power_in = product[VALUE_BITS-1:0];
               exp_in   = exp_ff + EXP_BITS'(1);
               pow_we   = 1'b1;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (remaining_ff >= power_ff) begin
               remaining_in = remaining_ff - power_ff;
               digit_in     = digit_ff + DIGIT_BITS'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (exp_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  exp_in   = exp_ff - EXP_BITS'(1);
                  power_in = pow_table_ff[exp_ff - EXP_BITS'(1)];
                  digit_in = '0;
                  state_in = ST_DIGIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The place power never exceeds the part of the value still to be emitted,
   // except for the unit power that a zero value starts with.
   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |->
         ((power_ff <= remaining_ff) || (power_ff == VALUE_BITS'(1))))
      else $error("place power above remaining value during search");

   // A presented digit has fully consumed its place and lies below the radix.
   a_digit_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((remaining_ff < power_ff) && (digit_ff < radix_ff)))
      else $error("digit presented before its place was fully consumed");

   // After the final digit transfer the block is ready for a new value.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("block not idle after the final digit transfer");

   // A new request starts with a place exponent of zero and a unit place power.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ((power_ff == VALUE_BITS'(1)) && (exp_ff == '0)))
      else $error("conversion started with a stale place power");

endmodule
